[src/llic_pkg.sv]
`timescale 1ns / 1ps
// Package for the link-list in-degree counter: default sizes, request codes,
// character codes and the enum types of the parser and the control sequencer.
// It depends on nothing else.

package llic_pkg;

    localparam int NODE_COUNT_DEF         = 4096;
    localparam int MAX_LINKS_PER_LINE_DEF = 128;
    localparam int COUNT_BITS_DEF         = 32;

    localparam int REQ_BITS   = 2;
    localparam int CHAR_BITS  = 8;
    localparam int INDEX_BITS = 12;
    localparam int OUT_BITS   = 32;

    localparam logic [REQ_BITS-1:0] REQ_CHAR  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_FLUSH = 2'd2;

    localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_BITS-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_COLON   = 8'h3A;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;

    localparam logic [1:0] COLONS_NONE = 2'd0;
    localparam logic [1:0] COLONS_ONE  = 2'd1;
    localparam logic [1:0] COLONS_MANY = 2'd2;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_NODE,
        PH_NODE_TAIL,
        PH_GAP,
        PH_LINK,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COMMIT
    } state_t;

endpackage

[src/llic_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of an address written in the same cycle returns the old data.
// No dependencies.

module llic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/link_list_indegree_counter.sv]
`timescale 1ns / 1ps
// Top level of the link-list in-degree counter. Uses llic_pkg and two
// instances of llic_ram (count memory and line buffer).

// The block reads adjacency-list text ("node : id id id", one line per
// newline) one character per transaction and counts, per link id, how many
// links in committed lines point at it. Character transactions are taken one
// per cycle while the block is idle and not stalled. A newline or a flush that
// ends a valid line starts a commit that walks the line buffer and does a
// read-modify-write of the count memory, one link per cycle, and holds off new
// transactions until the commit pipeline has drained. A read request does the
// count memory read, then the load of the output register. After reset the
// count memory is swept to zero one entry per cycle, so no transaction is
// taken until the sweep is done. Lines with a missing or extra colon, or no
// node id, are dropped quietly; otherwise a bad character, an out-of-range id
// or more than MAX_LINKS_PER_LINE links drops the line and sets a sticky
// error flag that parse_error shows with each read result. Counts saturate
// at all ones and are shown capped at 32 bits.

module link_list_indegree_counter #(
    parameter int NODE_COUNT         = llic_pkg::NODE_COUNT_DEF,
    parameter int MAX_LINKS_PER_LINE = llic_pkg::MAX_LINKS_PER_LINE_DEF,
    parameter int COUNT_BITS         = llic_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [llic_pkg::REQ_BITS-1:0]      req_type,
    input  logic [llic_pkg::CHAR_BITS-1:0]     char_code,
    input  logic [llic_pkg::INDEX_BITS-1:0]    node_index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [llic_pkg::OUT_BITS-1:0]      link_count,
    output logic                               parse_error
);

    // Id width, line buffer address width and link counter width.
    localparam int IDW = $clog2(NODE_COUNT);
    localparam int LAW = $clog2(MAX_LINKS_PER_LINE);
    localparam int PW  = $clog2(MAX_LINKS_PER_LINE + 1);
    localparam int XW  = (IDW > llic_pkg::INDEX_BITS) ? IDW : llic_pkg::INDEX_BITS;
    localparam int OW  = (COUNT_BITS > llic_pkg::OUT_BITS) ? COUNT_BITS : llic_pkg::OUT_BITS;

    localparam logic [IDW-1:0]        LAST_ID   = IDW'(NODE_COUNT - 1);
    localparam logic [PW-1:0]         MAX_LINKS = PW'(MAX_LINKS_PER_LINE);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};
    localparam logic [OW-1:0]         OUT_TOP   = OW'({llic_pkg::OUT_BITS{1'b1}});

    // Control and parser state.
    llic_pkg::state_t state_reg, state_next;
    llic_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       colons_reg, colons_next;
    logic             bad_reg, bad_next;
    logic             node_reg, node_next;
    logic [IDW-1:0]   tok_reg, tok_next;
    logic             big_reg, big_next;
    logic [PW-1:0]    pend_reg, pend_next;
    logic             err_reg, err_next;
    logic [IDW-1:0]   clr_reg, clr_next;

    // Commit pipeline: buffer read, count read, count write.
    logic [PW-1:0]         cm_len_reg, cm_len_next;
    logic [PW-1:0]         cm_idx_reg, cm_idx_next;
    logic                  b_valid_reg, b_valid_next;
    logic                  c_valid_reg, c_valid_next;
    logic [IDW-1:0]        c_id_reg, c_id_next;
    logic                  fwd_reg, fwd_next;
    logic [COUNT_BITS-1:0] fwd_data_reg, fwd_data_next;

    // Read request bookkeeping and the output register.
    logic                          rd_zero_reg, rd_zero_next;
    logic                          out_valid_reg, out_valid_next;
    logic [llic_pkg::OUT_BITS-1:0] link_count_reg, link_count_next;
    logic                          parse_error_reg, parse_error_next;

    // Memory ports.
    logic                  cnt_we;
    logic [IDW-1:0]        cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  cnt_re;
    logic [IDW-1:0]        cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic                  buf_we;
    logic [LAW-1:0]        buf_waddr;
    logic [IDW-1:0]        buf_wdata;
    logic                  buf_re;
    logic [LAW-1:0]        buf_raddr;
    logic [IDW-1:0]        buf_rdata;

    logic accept;

    llic_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NODE_COUNT)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    llic_ram #(
        .WIDTH (IDW),
        .DEPTH (MAX_LINKS_PER_LINE)
    ) u_line_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    // New transactions are taken only in idle, and only if the output
    // register is empty or being emptied in this cycle.
    assign in_stall    = (state_reg != llic_pkg::ST_IDLE) || (out_valid_reg && out_stall);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign link_count  = link_count_reg;
    assign parse_error = parse_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= llic_pkg::ST_CLEAR;
            phase_reg     <= llic_pkg::PH_LEAD;
            colons_reg    <= llic_pkg::COLONS_NONE;
            bad_reg       <= 1'b0;
            node_reg      <= 1'b0;
            tok_reg       <= '0;
            big_reg       <= 1'b0;
            pend_reg      <= '0;
            err_reg       <= 1'b0;
            clr_reg       <= '0;
            cm_len_reg    <= '0;
            cm_idx_reg    <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            colons_reg    <= colons_next;
            bad_reg       <= bad_next;
            node_reg      <= node_next;
            tok_reg       <= tok_next;
            big_reg       <= big_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            clr_reg       <= clr_next;
            cm_len_reg    <= cm_len_next;
            cm_idx_reg    <= cm_idx_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_id_reg        <= c_id_next;
        fwd_data_reg    <= fwd_data_next;
        rd_zero_reg     <= rd_zero_next;
        link_count_reg  <= link_count_next;
        parse_error_reg <= parse_error_next;
    end

    always_comb
    begin
        logic                  is_blank;
        logic                  is_digit;
        logic [3:0]            digit;
        logic [IDW+3:0]        prod;
        logic                  finish;
        logic                  end_line;
        logic [XW-1:0]         idx_ext;
        logic                  issue;
        logic [COUNT_BITS-1:0] cur;
        logic [COUNT_BITS-1:0] inc;
        logic [OW-1:0]         rd_ext;

        state_next       = state_reg;
        phase_next       = phase_reg;
        colons_next      = colons_reg;
        bad_next         = bad_reg;
        node_next        = node_reg;
        tok_next         = tok_reg;
        big_next         = big_reg;
        pend_next        = pend_reg;
        err_next         = err_reg;
        clr_next         = clr_reg;
        cm_len_next      = cm_len_reg;
        cm_idx_next      = cm_idx_reg;
        b_valid_next     = 1'b0;
        c_valid_next     = 1'b0;
        c_id_next        = c_id_reg;
        fwd_next         = 1'b0;
        fwd_data_next    = fwd_data_reg;
        rd_zero_next     = rd_zero_reg;
        link_count_next  = link_count_reg;
        parse_error_next = parse_error_reg;
        out_valid_next   = out_valid_reg && out_stall;

        cnt_we    = 1'b0;
        cnt_waddr = clr_reg;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = buf_rdata;
        buf_we    = 1'b0;
        buf_waddr = pend_reg[LAW-1:0];
        buf_wdata = tok_reg;
        buf_re    = 1'b0;
        buf_raddr = cm_idx_reg[LAW-1:0];

        is_blank = (char_code == llic_pkg::CHAR_SPACE)
                || ((char_code >= llic_pkg::CHAR_TAB) && (char_code <= llic_pkg::CHAR_CR));
        is_digit = (char_code >= llic_pkg::CHAR_ZERO) && (char_code <= llic_pkg::CHAR_NINE);
        digit    = 4'(char_code - llic_pkg::CHAR_ZERO);
        prod     = ((IDW + 4)'(tok_reg) << 3) + ((IDW + 4)'(tok_reg) << 1)
                 + (IDW + 4)'(digit);
        finish   = 1'b0;
        end_line = 1'b0;
        idx_ext  = XW'(node_index);
        issue    = cm_idx_reg < cm_len_reg;
        cur      = fwd_reg ? fwd_data_reg : cnt_rdata;
        inc      = (cur == COUNT_TOP) ? cur : cur + 1'b1;
        rd_ext   = OW'(cnt_rdata);

        unique case (state_reg)
            llic_pkg::ST_CLEAR:
            begin
                // Sweep the count memory to zero after reset.
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_ID)
                begin
                    state_next = llic_pkg::ST_IDLE;
                end
            end

            llic_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        llic_pkg::REQ_CHAR:
                        begin
                            if (char_code == llic_pkg::CHAR_NEWLINE)
                            begin
                                end_line = 1'b1;
                            end
                            else if (phase_reg == llic_pkg::PH_SKIP)
                            begin
                                // Rest of a line with a second colon is ignored.
                            end
                            else if (char_code == llic_pkg::CHAR_COLON)
                            begin
                                if (colons_reg == llic_pkg::COLONS_NONE)
                                begin
                                    colons_next = llic_pkg::COLONS_ONE;
                                    phase_next  = llic_pkg::PH_GAP;
                                end
                                else
                                begin
                                    colons_next = llic_pkg::COLONS_MANY;
                                    phase_next  = llic_pkg::PH_SKIP;
                                end
                            end
                            else if (is_blank)
                            begin
                                if (phase_reg == llic_pkg::PH_NODE)
                                begin
                                    phase_next = llic_pkg::PH_NODE_TAIL;
                                end
                                else if (phase_reg == llic_pkg::PH_LINK)
                                begin
                                    finish     = 1'b1;
                                    phase_next = llic_pkg::PH_GAP;
                                end
                            end
                            else if (is_digit)
                            begin
                                case (phase_reg)
                                    llic_pkg::PH_LEAD:
                                    begin
                                        phase_next = llic_pkg::PH_NODE;
                                        node_next  = 1'b1;
                                    end
                                    llic_pkg::PH_NODE_TAIL:
                                    begin
                                        bad_next = 1'b1;
                                    end
                                    llic_pkg::PH_GAP:
                                    begin
                                        tok_next   = IDW'(digit);
                                        big_next   = 1'b0;
                                        phase_next = llic_pkg::PH_LINK;
                                    end
                                    llic_pkg::PH_LINK:
                                    begin
                                        // Once out of range the token stays out of
                                        // range, so only the flag is kept.
                                        if (!big_reg)
                                        begin
                                            tok_next = prod[IDW-1:0];
                                            big_next = prod >= (IDW + 4)'(NODE_COUNT);
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                            else
                            begin
                                bad_next = 1'b1;
                                if (colons_reg == llic_pkg::COLONS_NONE)
                                begin
                                    node_next = 1'b1;
                                end
                            end
                        end

                        llic_pkg::REQ_READ:
                        begin
                            cnt_re       = 1'b1;
                            cnt_raddr    = idx_ext[IDW-1:0];
                            rd_zero_next = {1'b0, idx_ext} >= (XW + 1)'(NODE_COUNT);
                            state_next   = llic_pkg::ST_READ;
                        end

                        llic_pkg::REQ_FLUSH:
                        begin
                            end_line = 1'b1;
                        end

                        default:
                        begin
                        end
                    endcase

                    // A line ending inside a link token closes that token first.
                    if (end_line && (phase_reg == llic_pkg::PH_LINK))
                    begin
                        finish = 1'b1;
                    end

                    if (finish && !bad_reg)
                    begin
                        if (big_reg || (pend_reg >= MAX_LINKS))
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            buf_we    = 1'b1;
                            pend_next = pend_reg + 1'b1;
                        end
                    end

                    if (end_line)
                    begin
                        if ((colons_reg == llic_pkg::COLONS_ONE) && node_reg)
                        begin
                            if (bad_next)
                            begin
                                err_next = 1'b1;
                            end
                            else if (pend_next != '0)
                            begin
                                cm_len_next = pend_next;
                                cm_idx_next = '0;
                                state_next  = llic_pkg::ST_COMMIT;
                            end
                        end
                        phase_next  = llic_pkg::PH_LEAD;
                        colons_next = llic_pkg::COLONS_NONE;
                        bad_next    = 1'b0;
                        node_next   = 1'b0;
                        tok_next    = '0;
                        big_next    = 1'b0;
                        pend_next   = '0;
                    end
                end
            end

            llic_pkg::ST_READ:
            begin
                out_valid_next   = 1'b1;
                parse_error_next = err_reg;
                if (rd_zero_reg)
                begin
                    link_count_next = '0;
                end
                else if (rd_ext > OUT_TOP)
                begin
                    link_count_next = {llic_pkg::OUT_BITS{1'b1}};
                end
                else
                begin
                    link_count_next = rd_ext[llic_pkg::OUT_BITS-1:0];
                end
                state_next = llic_pkg::ST_IDLE;
            end

            llic_pkg::ST_COMMIT:
            begin
                // Stage one: fetch the next id from the line buffer.
                if (issue)
                begin
                    buf_re       = 1'b1;
                    cm_idx_next  = cm_idx_reg + 1'b1;
                    b_valid_next = 1'b1;
                end
                // Stage three: write back the saturated increment.
                if (c_valid_reg)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = c_id_reg;
                    cnt_wdata = inc;
                end
                // Stage two: read the count. The memory returns old data when
                // the same id is written in this cycle, so that value is
                // forwarded instead.
                if (b_valid_reg)
                begin
                    cnt_re        = 1'b1;
                    cnt_raddr     = buf_rdata;
                    c_valid_next  = 1'b1;
                    c_id_next     = buf_rdata;
                    fwd_next      = c_valid_reg && (c_id_reg == buf_rdata);
                    fwd_data_next = inc;
                end
                if (!issue && !b_valid_reg && !c_valid_reg)
                begin
                    state_next = llic_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = llic_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
